@@ rtl/upd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_pkg
// Shared types, character codes and hex helpers for the percent decoder.
// ----------------------------------------------------------------------------
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // Most results one request can cause
  localparam int unsigned MAX_RES = 3;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } res_item_t;

  // Results of one request: item[0] goes out first
  typedef struct packed {
    logic [1:0]                  cnt;
    res_item_t [MAX_RES-1:0]     item;
  } res_set_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) ||
             (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  // Nibble of a hex digit; only meaningful where is_hex holds
  function automatic logic [3:0] nibble_of(input logic [7:0] c);
    logic [7:0] v;
    if (c <= 8'h39) begin
      v = c - 8'h30;
    end else if (c <= 8'h46) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h57;
    end
    nibble_of = v[3:0];
  endfunction

endpackage
`default_nettype wire

@@ rtl/upd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_core
// Escape state, mode register and per-request decode into up to three results.
// ----------------------------------------------------------------------------
module upd_core (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_we,
  input  wire logic            cfg_bit,
  input  wire logic            acc,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_last,
  output upd_pkg::res_set_t    res
);
  import upd_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       query_r;
  logic       hex;
  logic       plain_go;
  logic [1:0] k;
  logic [7:0] pb;

  assign hex = is_hex(in_byte);
  assign pb  = (in_byte == CH_PLUS && query_r) ? CH_SPACE : in_byte;

  always_comb begin
    res       = '0;
    k         = 2'd0;
    phase_nxt = phase_r;
    held_nxt  = held_r;
    plain_go  = 1'b0;
    case (phase_r)
      PH_PCT: begin
        if (hex && !in_last) begin
          held_nxt  = in_byte;
          phase_nxt = PH_DIGIT;
        end else begin
          res.item[0] = '{data: CH_PERCENT, last: 1'b0};
          k           = 2'd1;
          plain_go    = 1'b1;
        end
      end
      PH_DIGIT: begin
        if (hex) begin
          res.item[0] = '{data: {nibble_of(held_r), nibble_of(in_byte)}, last: in_last};
          k           = 2'd1;
          phase_nxt   = PH_IDLE;
        end else begin
          res.item[0] = '{data: CH_PERCENT, last: 1'b0};
          res.item[1] = '{data: held_r, last: 1'b0};
          k           = 2'd2;
          plain_go    = 1'b1;
        end
      end
      default: begin
        plain_go = 1'b1;
      end
    endcase
    if (plain_go) begin
      if (in_byte == CH_PERCENT && !in_last) begin
        phase_nxt = PH_PCT;
      end else begin
        res.item[k] = '{data: pb, last: in_last};
        k           = k + 2'd1;
        phase_nxt   = PH_IDLE;
      end
    end
    if (in_last) begin
      phase_nxt = PH_IDLE;
    end
    res.cnt = k;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      held_r  <= 8'h00;
      query_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        query_r <= cfg_bit;
      end
      if (acc) begin
        phase_r <= phase_nxt;
        held_r  <= held_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/upd_obuf.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// upd_obuf
// Three-entry result queue; the head entry drives the output channel.
// ----------------------------------------------------------------------------
module upd_obuf (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire upd_pkg::res_set_t  res,
  input  wire logic               out_tready,
  output logic                    out_tvalid,
  output logic [7:0]              out_tdata,
  output logic                    out_tlast,
  output logic                    room
);
  import upd_pkg::*;

  res_item_t [MAX_RES-1:0] q_r, q_nxt;
  logic [1:0]              cnt_r, cnt_nxt;
  logic                    pop;
  logic [1:0]              base;
  logic [1:0]              add;
  logic [2:0]              src;
  logic [1:0]              j;

  assign pop        = (cnt_r != 2'd0) && out_tready;
  assign base       = cnt_r - {1'b0, pop};
  assign add        = push ? res.cnt : 2'd0;
  // A request can add three results only once the queue is empty or emptying
  assign room       = (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_tready);
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = q_r[0].data;
  assign out_tlast  = q_r[0].last;

  always_comb begin
    q_nxt = q_r;
    src   = 3'd0;
    j     = 2'd0;
    for (int i = 0; i < MAX_RES; i++) begin
      src = 3'(i) + {2'b00, pop};
      j   = 2'(i) - base;
      if (src < {1'b0, cnt_r}) begin
        q_nxt[i] = q_r[src[1:0]];
      end else if (2'(i) >= base && j < add) begin
        q_nxt[i] = res.item[j];
      end
    end
    cnt_nxt = base + add;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/url_percent_decoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// url_percent_decoder
// Streaming percent-decoder for one URL component, one byte per request.
// ----------------------------------------------------------------------------
//  channel | direction | payload                         | handshake
//  in_     | slave     | tdata = encoded byte, tlast     | in_tvalid / in_tready
//  out_    | master    | tdata = decoded byte, tlast     | out_tvalid / out_tready
//  cfg_    | slave     | data = query_mode (bit 0)       | cfg_valid / cfg_ready
//
// A request is decoded in the cycle it is taken and its results land in a
// three-entry queue that drives the output; the queue is registered, so no
// result shows in the cycle of its request. Steady rate is one byte per cycle
// while out_tready is high: a failed escape yields up to three results from one
// request, and the input then holds while the queue drains one result a cycle.
// Reset (rst_n low, synchronous) empties the queue, clears any pending escape
// and sets path mode. cfg_ready is always high.
// ----------------------------------------------------------------------------
module url_percent_decoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // Configuration write
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data,     // [0] query_mode
  // Encoded byte stream
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,     // [7:0] in_byte
  input  wire logic       in_tlast,
  // Decoded byte stream
  output logic            out_tvalid,
  input  wire logic       out_tready,
  output logic [7:0]      out_tdata,    // [7:0] out_byte
  output logic            out_tlast
);
  import upd_pkg::*;

  res_set_t res;
  logic     acc;
  logic     room;

  // Take a request whenever the queue can hold its worst case
  assign in_tready = room;
  assign acc       = in_tvalid && room;
  assign cfg_ready = 1'b1;

  upd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_we  (cfg_valid),
    .cfg_bit (cfg_data),
    .acc     (acc),
    .in_byte (in_tdata),
    .in_last (in_tlast),
    .res     (res)
  );

  upd_obuf u_obuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (acc),
    .res        (res),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .room       (room)
  );

endmodule
`default_nettype wire

@@ sim/url_percent_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// url_percent_decoder_tb
// Self-checking bench for the streaming percent-decoder. A directed set of
// escapes, broken escapes and end-of-component cuts runs first. Randomised
// components then run under several idle and stall patterns and both modes.
// Each result byte is checked against a behavioural decoder in the order the
// requests were taken.
// ----------------------------------------------------------------------------
module url_percent_decoder_tb;

  import upd_pkg::*;

  // Hard stop for a hung run: far above the slowest legal run
  localparam int unsigned RUN_LIMIT_NS = 2_000_000;
  // Minimum items per random phase
  localparam int unsigned PHASE_ITEMS  = 41;

  typedef struct {
    logic [7:0] val;
    logic       last;
  } enc_byte_t;

  typedef struct {
    logic [7:0] val;
    logic       last;
  } dec_byte_t;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       cfg_valid  = 1'b0;
  logic       cfg_ready;
  logic       cfg_data   = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata   = 8'h00;     // [7:0] in_byte
  logic       in_tlast   = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;              // [7:0] out_byte
  logic       out_tlast;

  // Requests still to be offered, and decoded bytes still awaited
  enc_byte_t  pending_q[$];
  dec_byte_t  decoded_q[$];
  enc_byte_t  next_req;
  dec_byte_t  want;

  int unsigned queued_cnt   = 0;
  int unsigned accepted_cnt = 0;
  int unsigned fail_cnt     = 0;
  int unsigned send_gap_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        in_fire      = 1'b0;

  // Decoder state mirrored by the bench
  phase_t      esc_state = PH_IDLE;
  logic [7:0]  held_hex  = 8'h00;
  logic        query_on  = 1'b0;

  url_percent_decoder i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Behavioural decoder
  // --------------------------------------------------------------------------
  function automatic logic hex_ok(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Only meaningful where hex_ok holds
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else if (c <= "F") begin
      v = c - "A" + 8'd10;
    end else begin
      v = c - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  function automatic void expect_byte(input logic [7:0] v, input logic l);
    dec_byte_t d;
    d.val  = v;
    d.last = l;
    decoded_q.push_back(d);
  endfunction

  // Ordinary byte: open an escape on a non-final percent, else pass it on
  function automatic void take_plain(input logic [7:0] v, input logic l);
    if (v == CH_PERCENT && !l) begin
      esc_state = PH_PCT;
    end else begin
      expect_byte((v == CH_PLUS && query_on) ? CH_SPACE : v, l);
      esc_state = PH_IDLE;
    end
  endfunction

  function automatic void decode_request(input logic [7:0] v, input logic l);
    case (esc_state)
      PH_PCT: begin
        if (hex_ok(v) && !l) begin
          held_hex  = v;
          esc_state = PH_DIGIT;
        end else begin
          // Broken or cut-short escape: the percent goes out literally
          expect_byte(CH_PERCENT, 1'b0);
          esc_state = PH_IDLE;
          take_plain(v, l);
        end
      end
      PH_DIGIT: begin
        if (hex_ok(v)) begin
          expect_byte({hex_nibble(held_hex), hex_nibble(v)}, l);
          esc_state = PH_IDLE;
        end else begin
          expect_byte(CH_PERCENT, 1'b0);
          expect_byte(held_hex, 1'b0);
          esc_state = PH_IDLE;
          take_plain(v, l);
        end
      end
      default: begin
        // The spare phase code behaves as idle
        esc_state = PH_IDLE;
        take_plain(v, l);
      end
    endcase
    if (l) begin
      esc_state = PH_IDLE;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: present requests and stall the output, all on the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    // Advance only once the current request has gone, otherwise hold it
    if (!in_tvalid || in_fire) begin
      if (pending_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        next_req  = pending_q.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= next_req.val;
        in_tlast  <= next_req.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    out_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: predict on each taken request, check each result byte
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_fire <= in_tvalid && in_tready;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        query_on = cfg_data;
      end
      // Predict first so that a same-edge result would still find its match
      if (in_tvalid && in_tready) begin
        decode_request(in_tdata, in_tlast);
        accepted_cnt++;
      end
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $error("out_byte: expected nothing, got %02h (out_last %0b)", out_tdata, out_tlast);
          fail_cnt++;
        end else begin
          want = decoded_q.pop_front();
          if (out_tdata !== want.val) begin
            $error("out_byte: expected %02h, got %02h", want.val, out_tdata);
            fail_cnt++;
          end
          if (out_tlast !== want.last) begin
            $error("out_last: expected %0b, got %0b", want.last, out_tlast);
            fail_cnt++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic put_item(input logic [7:0] v, input logic l);
    enc_byte_t e;
    e.val  = v;
    e.last = l;
    pending_q.push_back(e);
    queued_cnt++;
  endtask

  task automatic push_text(input string s, input logic end_last);
    for (int i = 0; i < s.len(); i++) begin
      put_item(s[i], end_last && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pick_hex();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) begin
      return 8'h30 + 8'(r);
    end else if (r < 16) begin
      return 8'h41 + 8'(r - 10);
    end
    return 8'h61 + 8'(r - 16);
  endfunction

  function automatic logic [7:0] pick_non_hex();
    logic [7:0] v;
    do begin
      v = 8'($urandom_range(0, 255));
    end while (hex_ok(v));
    return v;
  endfunction

  // Build one component from one to six tokens: plain bytes, pluses and
  // well-formed escapes, with broken and truncated ones mixed in; tlast goes on its final byte
  task automatic queue_component();
    logic [7:0]  text[$];
    int unsigned n_tok;
    n_tok = $urandom_range(1, 6);
    repeat (n_tok) begin
      case ($urandom_range(0, 9))
        0, 1: text.push_back(8'($urandom_range(0, 255)));
        2:    text.push_back(CH_PLUS);
        3, 4: begin
          text.push_back(CH_PERCENT);
          text.push_back(pick_hex());
          text.push_back(pick_hex());
        end
        5: begin
          text.push_back(CH_PERCENT);
          text.push_back(pick_non_hex());
        end
        6: begin
          text.push_back(CH_PERCENT);
          text.push_back(pick_hex());
          text.push_back(pick_non_hex());
        end
        7: text.push_back(CH_PERCENT);
        8: begin
          text.push_back(CH_PERCENT);
          text.push_back(pick_hex());
        end
        default: text.push_back(8'($urandom_range(8'h21, 8'h7E)));
      endcase
    end
    foreach (text[i]) begin
      put_item(text[i], i == text.size() - 1);
    end
  endtask

  task automatic write_query(input logic q);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every request is taken and every result has arrived, then
  // allow for a request still in flight that produces nothing
  task automatic wait_quiet();
    do @(negedge clk); while (accepted_cnt != queued_cnt || decoded_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_idling(input int unsigned mode);
    case (mode)
      0: begin send_gap_pct = 0;  rx_stall_pct = 0;  end
      1: begin send_gap_pct = 87; rx_stall_pct = 0;  end
      2: begin send_gap_pct = 0;  rx_stall_pct = 87; end
      default: begin send_gap_pct = 29; rx_stall_pct = 29; end
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned mark;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part in query mode
    set_idling(3);
    write_query(1'b1);
    put_item(8'h00, 1'b0);
    put_item(8'hFF, 1'b0);
    put_item(CH_PLUS, 1'b0);        // plus becomes space
    push_text("%41", 1'b0);         // plain escape
    push_text("%fF", 1'b1);         // mixed case, decoded byte carries tlast
    push_text("%G", 1'b0);          // bad first digit
    push_text("%a%41", 1'b0);       // bad second digit that opens a new escape
    push_text("%%7", 1'b1);         // second percent restarts, then cut by the end
    push_text("%", 1'b1);           // lone percent at the end
    push_text("%3z", 1'b1);         // bad second digit on the final byte
    wait_quiet();

    // Plus passes through untouched in path mode
    write_query(1'b0);
    push_text("+", 1'b1);
    wait_quiet();

    // Random phases over every idling pattern, both modes
    for (int p = 0; p < 8; p++) begin
      set_idling(p % 4);
      write_query(((p & 1) ^ ((p >> 2) & 1)) != 0);
      mark = queued_cnt;
      while (queued_cnt - mark < PHASE_ITEMS) begin
        if ($urandom_range(0, 9) == 0) begin
          // Noise: any byte with a random end flag
          put_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else begin
          queue_component();
        end
      end
      wait_quiet();
    end

    repeat (8) @(negedge clk);
    if (fail_cnt == 0) begin
      $display("url_percent_decoder_tb passed");
    end else begin
      $display("url_percent_decoder_tb failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("url_percent_decoder_tb failed");
    $finish;
  end

endmodule
